// ===== design/bmhq_pkg.sv =====
// shared types and constants for the binary min-heap queue
// no dependencies; imported by bmhq_ctrl, the top level and the testbench
package bmhq_pkg;

    localparam int KEY_W            = 32;
    localparam int TAG_W            = 16;
    localparam int MODE_W           = 2;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 9;
    localparam int ENTRY_W          = KEY_W + TAG_W;
    localparam int DEFAULT_CAPACITY = 256;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    typedef struct packed {
        status_t              status;
        entry_t               removed;
        entry_t               top;
        logic [COUNT_W-1:0]   count;
    } result_t;

endpackage

// ===== design/bmhq_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bmhq_ctrl.sv =====
// heap sequencer: insert sift-up, delete sift-down, clear, root cache and count
// depends on bmhq_pkg; drives the heap ram ports
module bmhq_ctrl
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        in_mode,
    input  logic signed [KEY_W-1:0]  in_key,
    input  logic [TAG_W-1:0]         in_tag,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res,
    output logic                     ram_we,
    output logic [AW-1:0]            ram_waddr,
    output logic [ENTRY_W-1:0]       ram_wdata,
    output logic                     ram_re,
    output logic [AW-1:0]            ram_raddr,
    input  logic [ENTRY_W-1:0]       ram_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_WR,
        ST_DEL_LAST,
        ST_DL_L,
        ST_DL_R,
        ST_DL_WR,
        ST_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    entry_t          new_reg, new_next;
    entry_t          left_reg, left_next;
    entry_t          root_reg, root_next;
    entry_t          removed_reg, removed_next;
    status_t         status_reg, status_next;

    entry_t          rd_entry;
    entry_t          wr_entry;
    entry_t          in_entry;
    logic [CW:0]     node_w, left_w, right_w, count_w, child_w, grand_w;
    logic [AW-1:0]   par_in, par_idx, par_par;
    logic            l_smaller, r_smaller;
    logic [CW+COUNT_W-1:0] count_x;

    assign rd_entry  = entry_t'(ram_rdata);
    assign in_entry  = '{key: in_key, tag: in_tag};
    assign ram_wdata = ENTRY_W'(wr_entry);

    // heap index arithmetic
    assign node_w  = {{(CW + 1 - AW){1'b0}}, idx_reg};
    assign left_w  = (node_w << 1) | {{CW{1'b0}}, 1'b1};
    assign right_w = left_w + {{CW{1'b0}}, 1'b1};
    assign count_w = {1'b0, count_reg};
    assign par_in  = (count_reg[AW-1:0] - {{(AW-1){1'b0}}, 1'b1}) >> 1;
    assign par_idx = (idx_reg - {{(AW-1){1'b0}}, 1'b1}) >> 1;
    assign par_par = (par_idx - {{(AW-1){1'b0}}, 1'b1}) >> 1;

    assign l_smaller = left_reg.key < new_reg.key;
    assign r_smaller = rd_entry.key < (l_smaller ? left_reg.key : new_reg.key);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        new_next     = new_reg;
        left_next    = left_reg;
        root_next    = root_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        wr_entry     = new_reg;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        child_w      = left_w;
        grand_w      = (left_w << 1) | {{CW{1'b0}}, 1'b1};
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    removed_next = '0;
                    status_next  = STATUS_OK;
                    state_next   = ST_FIN;
                    unique case (mode_t'(in_mode))
                        MODE_INSERT: begin
                            if (count_reg == CAP_C) begin
                                status_next = STATUS_OVERFLOW;
                            end else begin
                                idx_next   = count_reg[AW-1:0];
                                new_next   = in_entry;
                                count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
                                if (count_reg == '0) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = '0;
                                    wr_entry  = in_entry;
                                end else begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = par_in;
                                    state_next = ST_INS_CMP;
                                end
                            end
                        end
                        MODE_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_UNDERFLOW;
                            end else begin
                                removed_next = root_reg;
                                count_next   = count_reg - {{(CW-1){1'b0}}, 1'b1};
                                idx_next     = '0;
                                if (count_reg != {{(CW-1){1'b0}}, 1'b1}) begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = count_next[AW-1:0];
                                    state_next = ST_DEL_LAST;
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INS_CMP: begin
                ram_we = 1'b1;
                if (new_reg.key < rd_entry.key) begin
                    // parent moves down one level
                    wr_entry = rd_entry;
                    idx_next = par_idx;
                    if (par_idx != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = par_par;
                    end else begin
                        state_next = ST_INS_WR;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_INS_WR, ST_DL_WR: begin
                ram_we     = 1'b1;
                state_next = ST_FIN;
            end
            ST_DEL_LAST: begin
                new_next = rd_entry;
                if (left_w < count_w) begin
                    ram_re     = 1'b1;
                    ram_raddr  = left_w[AW-1:0];
                    state_next = ST_DL_L;
                end else begin
                    ram_we     = 1'b1;
                    wr_entry   = rd_entry;
                    state_next = ST_FIN;
                end
            end
            ST_DL_L: begin
                left_next = rd_entry;
                if (right_w < count_w) begin
                    ram_re     = 1'b1;
                    ram_raddr  = right_w[AW-1:0];
                    state_next = ST_DL_R;
                end else begin
                    ram_we = 1'b1;
                    if (rd_entry.key < new_reg.key) begin
                        wr_entry = rd_entry;
                        child_w  = left_w;
                        idx_next = child_w[AW-1:0];
                        if (grand_w < count_w) begin
                            ram_re    = 1'b1;
                            ram_raddr = grand_w[AW-1:0];
                        end else begin
                            state_next = ST_DL_WR;
                        end
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DL_R: begin
                ram_we = 1'b1;
                if (r_smaller || l_smaller) begin
                    // left wins ties: right taken only when strictly smaller
                    child_w  = r_smaller ? right_w : left_w;
                    grand_w  = (child_w << 1) | {{CW{1'b0}}, 1'b1};
                    wr_entry = r_smaller ? rd_entry : left_reg;
                    idx_next = child_w[AW-1:0];
                    if (grand_w < count_w) begin
                        ram_re     = 1'b1;
                        ram_raddr  = grand_w[AW-1:0];
                        state_next = ST_DL_L;
                    end else begin
                        state_next = ST_DL_WR;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // root cache follows every write of index zero
        if (ram_we && ram_waddr == '0) begin
            root_next = wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg     <= idx_next;
        new_reg     <= new_next;
        left_reg    <= left_next;
        root_reg    <= root_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign count_x     = {{COUNT_W{1'b0}}, count_reg};
    assign res.status  = status_reg;
    assign res.removed = removed_reg;
    assign res.top     = (count_reg != '0) ? root_reg : '0;
    assign res.count   = count_x[COUNT_W-1:0];

endmodule

// ===== design/binary_min_heap_queue_unit.sv =====
// top level of the binary min-heap priority queue
// depends on bmhq_pkg, bmhq_ctrl and bmhq_ram
//
// Priority queue of up to CAPACITY entries (signed 32-bit key, 16-bit tag)
// kept as a binary min-heap in one synchronous ram. Each input word is one
// operation: insert, delete-min, clear, or no operation for the unused mode
// code. Every operation returns exactly one result word with the status, the
// removed entry (delete only), the entry at the root afterwards and the count.
// Operations are handled one at a time by a sequencer; the ram has one read
// and one write port and registered read data. Insert climbs one level at a
// time; delete-min descends one level at a time and reads the left and, where
// it exists, the right child of each level through the single read port. The
// next word is accepted only once the result has been passed on to the output
// register. The result sits in an output register, so the next word is taken
// while a result waits downstream.
// The ram needs no clearing after reset: only entries below the count are read.
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // operation words
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [MODE_W-1:0]        s_mode,
    input  logic signed [KEY_W-1:0]  s_key,
    input  logic [TAG_W-1:0]         s_tag,
    // result words
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic signed [KEY_W-1:0]  m_removed_key,
    output logic [TAG_W-1:0]         m_removed_tag,
    output logic signed [KEY_W-1:0]  m_top_key,
    output logic [TAG_W-1:0]         m_top_tag,
    output logic [COUNT_W-1:0]       m_entry_count
);

    localparam int AW = $clog2(CAPACITY);

    // sequencer to result register
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // heap ram ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // output register
    logic    m_valid_reg;
    result_t out_reg;

    bmhq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_mode   (s_mode),
        .in_key    (s_key),
        .in_tag    (s_tag),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // heap storage, one entry per word: key in the upper bits, tag below
    bmhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_heap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register loads when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = STATUS_W'(out_reg.status);
    assign m_removed_key = out_reg.removed.key;
    assign m_removed_tag = out_reg.removed.tag;
    assign m_top_key     = out_reg.top.key;
    assign m_top_tag     = out_reg.top.tag;
    assign m_entry_count = out_reg.count;

endmodule

// ===== test/tb_binary_min_heap_queue_unit.sv =====
// self-checking testbench for binary_min_heap_queue_unit (min-heap priority queue)
// depends on bmhq_pkg and the block's rtl; expected words come from a shadow heap
// kept in the bench and are compared field by field with every result word
module tb_binary_min_heap_queue_unit
    import bmhq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH  = DEFAULT_CAPACITY;
    localparam int RANDOM_OPS  = 1050;
    localparam int HOLD_AFTER  = 300;     // results seen before the long sink stall
    localparam int HOLD_CYCLES = 200;     // length of that stall
    localparam int TAIL_CYCLES = 40;      // quiet time after the last result
    localparam int CYCLE_LIMIT = 400000;

    // one operation word as the sender offers it
    typedef struct packed {
        mode_t                   mode;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } heap_op_t;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode  = '0;
    logic signed [KEY_W-1:0] s_key   = '0;
    logic [TAG_W-1:0]        s_tag   = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic signed [KEY_W-1:0] m_removed_key;
    logic [TAG_W-1:0]        m_removed_tag;
    logic signed [KEY_W-1:0] m_top_key;
    logic [TAG_W-1:0]        m_top_tag;
    logic [COUNT_W-1:0]      m_entry_count;

    // words still to be offered, and results still owed by the block
    heap_op_t pending_ops[$];
    result_t  awaited_results[$];

    // shadow copy of the heap, updated as each word is accepted
    entry_t shadow_heap [HEAP_DEPTH];
    int     shadow_len = 0;
    int     plan_len   = 0;    // entry count as the stimulus plan sees it

    // coverage tallies for the summary
    int n_insert = 0, n_delete = 0, n_clear = 0, n_nop = 0;
    int n_overflow = 0, n_underflow = 0, peak_len = 0;

    int results_checked = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    // idle bookkeeping, each side owns its own pair
    int src_gap = 0, src_calm = 0;
    int snk_gap = 0, snk_calm = 0;
    bit sink_hold = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    binary_min_heap_queue_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key         (s_key),
        .s_tag         (s_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_removed_key (m_removed_key),
        .m_removed_tag (m_removed_tag),
        .m_top_key     (m_top_key),
        .m_top_tag     (m_top_tag),
        .m_entry_count (m_entry_count)
    );

    // signed key order, ties count as not below
    function automatic bit key_below(entry_t a, entry_t b);
        return $signed(a.key) < $signed(b.key);
    endfunction

    // apply one operation to the shadow heap and return the word it must produce
    function automatic result_t apply_heap_op(mode_t mode, logic signed [KEY_W-1:0] key,
                                              logic [TAG_W-1:0] tag);
        result_t res;
        entry_t  fresh;
        entry_t  tmp;
        int      slot, left, right, best;
        bit      settled;
        res       = '0;
        fresh.key = key;
        fresh.tag = tag;
        case (mode)
            MODE_INSERT: begin
                n_insert++;
                if (shadow_len >= HEAP_DEPTH) begin
                    res.status = STATUS_OVERFLOW;
                    n_overflow++;
                end else begin
                    // climb while the parent is strictly greater
                    slot = shadow_len;
                    shadow_len++;
                    while (slot > 0 && key_below(fresh, shadow_heap[(slot - 1) / 2])) begin
                        shadow_heap[slot] = shadow_heap[(slot - 1) / 2];
                        slot = (slot - 1) / 2;
                    end
                    shadow_heap[slot] = fresh;
                end
            end
            MODE_DELETE: begin
                n_delete++;
                if (shadow_len == 0) begin
                    res.status = STATUS_UNDERFLOW;
                    n_underflow++;
                end else begin
                    res.removed = shadow_heap[0];
                    shadow_len--;
                    shadow_heap[0] = shadow_heap[shadow_len];
                    // sink: left child wins a tie between children, parent wins a tie
                    slot    = 0;
                    settled = 1'b0;
                    while (!settled) begin
                        left  = 2 * slot + 1;
                        right = left + 1;
                        best  = slot;
                        if (left < shadow_len && key_below(shadow_heap[left], shadow_heap[slot]))
                            best = left;
                        if (right < shadow_len && key_below(shadow_heap[right], shadow_heap[best]))
                            best = right;
                        if (best == slot) begin
                            settled = 1'b1;
                        end else begin
                            tmp               = shadow_heap[slot];
                            shadow_heap[slot] = shadow_heap[best];
                            shadow_heap[best] = tmp;
                            slot              = best;
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                n_clear++;
                shadow_len = 0;
            end
            default: begin
                n_nop++;
            end
        endcase
        if (shadow_len > 0)
            res.top = shadow_heap[0];
        res.count = COUNT_W'(shadow_len);
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        return res;
    endfunction

    // idle length after a handshake: mostly none or short, now and then long,
    // with stretches of back-to-back traffic
    task automatic next_gap(inout int calm_left, output int gap);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if (roll < 3) begin
            calm_left = $urandom_range(20, 60);
            gap       = 0;
        end else if (roll < 55) begin
            gap = 0;
        end else if (roll < 85) begin
            gap = $urandom_range(1, 3);
        end else if (roll < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 48);
        end
    endtask

    task automatic check_field(input string label, input logic signed [63:0] wanted,
                               input logic signed [63:0] got);
        if (got !== wanted) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, wanted, got);
        end
    endtask

    // keys: full range, a tight cluster for ties, and values near both extremes
    function automatic logic signed [KEY_W-1:0] pick_key(bit tight);
        int roll;
        int near;
        roll = $urandom_range(0, 9);
        near = $urandom_range(0, 8);
        if (tight || roll == 6 || roll == 7)
            return near - 4;
        else if (roll == 8)
            return 32'h8000_0000 + $urandom_range(0, 3);
        else if (roll == 9)
            return 32'h7fff_ffff - $urandom_range(0, 3);
        else
            return $urandom;
    endfunction

    // queue one word and track the count the block will hold after it
    task automatic plan_op(input mode_t mode, input logic signed [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag);
        heap_op_t op;
        op.mode = mode;
        op.key  = key;
        op.tag  = tag;
        pending_ops.push_back(op);
        case (mode)
            MODE_INSERT: if (plan_len < HEAP_DEPTH) plan_len++;
            MODE_DELETE: if (plan_len > 0) plan_len--;
            MODE_CLEAR:  plan_len = 0;
            default:     ;
        endcase
    endtask

    // random mix; unused key and tag fields of non-inserts carry noise
    task automatic plan_mixed(input int n, input int insert_pct, input bit tight);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                plan_op(MODE_INSERT, pick_key(tight), TAG_W'($urandom));
            else if (roll < 95)
                plan_op(MODE_DELETE, $urandom, TAG_W'($urandom));
            else if (roll < 98)
                plan_op(MODE_NOP, $urandom, TAG_W'($urandom));
            else
                plan_op(MODE_CLEAR, $urandom, TAG_W'($urandom));
        end
    endtask

    // fill to capacity, then push a few more to hit overflow
    task automatic plan_fill();
        while (plan_len < HEAP_DEPTH)
            plan_op(MODE_INSERT, pick_key(1'b0), TAG_W'($urandom));
        repeat ($urandom_range(2, 4))
            plan_op(MODE_INSERT, pick_key(1'b0), TAG_W'($urandom));
    endtask

    // empty by delete-min, then a few more to hit underflow
    task automatic plan_drain();
        while (plan_len > 0)
            plan_op(MODE_DELETE, $urandom, TAG_W'($urandom));
        repeat ($urandom_range(1, 3))
            plan_op(MODE_DELETE, $urandom, TAG_W'($urandom));
    endtask

    // sender: predicts each accepted word, then offers the next after its gap
    always @(posedge aclk) begin : op_driver
        heap_op_t next_op;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_heap_op(mode_t'(s_mode), s_key, s_tag));
                next_gap(src_calm, src_gap);
            end
            // a word still waiting for ready stays put with its payload
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    next_op = pending_ops.pop_front();
                    s_valid <= 1'b1;
                    s_mode  <= next_op.mode;
                    s_key   <= next_op.key;
                    s_tag   <= next_op.tag;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result word against the oldest prediction
    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result word with none expected, status %0d, count %0d",
                             $time, m_status, m_entry_count);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 64'(want.status), 64'(m_status));
                    check_field("removed_key", 64'(want.removed.key), 64'(m_removed_key));
                    check_field("removed_tag", 64'(want.removed.tag), 64'(m_removed_tag));
                    check_field("top_key", 64'(want.top.key), 64'(m_top_key));
                    check_field("top_tag", 64'(want.top.tag), 64'(m_top_tag));
                    check_field("entry_count", 64'(want.count), 64'(m_entry_count));
                end
                results_checked <= results_checked + 1;
                next_gap(snk_calm, snk_gap);
            end
            if (sink_hold || snk_gap > 0) begin
                m_ready <= 1'b0;
                if (snk_gap > 0)
                    snk_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // one long sink stall partway through so the block backs up into s_ready
    always @(posedge aclk) begin : sink_holdoff
        if (aresetn && !hold_done) begin
            if (sink_hold) begin
                hold_left--;
                if (hold_left == 0) begin
                    sink_hold <= 1'b0;
                    hold_done = 1'b1;
                end
            end else if (results_checked >= HOLD_AFTER) begin
                sink_hold <= 1'b1;
                hold_left = HOLD_CYCLES;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still owed", $time, awaited_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus_plan
        int target;
        int segment;

        // directed: empty-heap corner cases first
        plan_op(MODE_DELETE, 32'h1234_5678, 16'hbeef);   // underflow on empty
        plan_op(MODE_NOP, 32'hffff_ffff, 16'hffff);      // unused mode on empty
        plan_op(MODE_CLEAR, 32'h0, 16'h0);               // clear while empty
        // key extremes and equal keys with distinct tags
        plan_op(MODE_INSERT, 32'h0000_0000, 16'h0000);
        plan_op(MODE_INSERT, 32'h7fff_ffff, 16'hffff);
        plan_op(MODE_INSERT, 32'h8000_0000, 16'h1234);
        plan_op(MODE_INSERT, 32'hffff_ffff, 16'habcd);
        plan_op(MODE_INSERT, 32'd5, 16'h0001);
        plan_op(MODE_INSERT, 32'd5, 16'h0002);
        plan_op(MODE_INSERT, 32'd5, 16'h0003);
        plan_op(MODE_NOP, 32'h5555_5555, 16'h5555);      // no-op on a populated heap
        repeat (5)
            plan_op(MODE_DELETE, 32'haaaa_aaaa, 16'haaaa);
        plan_op(MODE_INSERT, 32'd5, 16'h0004);
        plan_op(MODE_CLEAR, 32'h0, 16'h0);               // clear with entries held
        plan_op(MODE_DELETE, 32'h0, 16'h0);              // underflow right after clear
        plan_op(MODE_INSERT, 32'd7, 16'h5555);
        plan_op(MODE_INSERT, 32'd7, 16'haaaa);
        repeat (3)
            plan_op(MODE_DELETE, 32'h0, 16'h0);          // last one underflows

        // random: one guaranteed full fill and drain, then a random mix of segments
        target = pending_ops.size() + RANDOM_OPS;
        plan_mixed(60, 70, 1'b0);
        plan_fill();
        plan_mixed(40, 50, 1'b1);
        plan_drain();
        while (pending_ops.size() < target) begin
            segment = $urandom_range(0, 9);
            case (segment)
                0, 1, 2, 3, 4: plan_mixed($urandom_range(30, 80), $urandom_range(35, 75), 1'b0);
                5, 6:          plan_mixed($urandom_range(20, 50), $urandom_range(45, 70), 1'b1);
                7: begin
                    plan_op(MODE_CLEAR, $urandom, TAG_W'($urandom));
                    plan_mixed(20, 80, 1'b0);
                end
                8:       plan_fill();
                default: plan_drain();
            endcase
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // sampled mid-cycle, away from the driving edge
        while (pending_ops.size() != 0 || awaited_results.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d words: %0d insert, %0d delete-min, %0d clear, %0d unused mode",
                 n_insert + n_delete + n_clear + n_nop, n_insert, n_delete, n_clear, n_nop);
        $display("hit %0d overflows and %0d underflows, peak depth %0d, %0d results checked",
                 n_overflow, n_underflow, peak_len, results_checked);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
